// ----- rtl/core/rssi_sweep_averager_macros.svh -----
// Assertion macros shared by the RSSI sweep averager RTL.
`ifndef RSSI_SWEEP_AVERAGER_MACROS_SVH
`define RSSI_SWEEP_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define RSA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rssi_sweep_averager assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rssi_sweep_averager assertion failed");

`else

`define RSA_ASSERT(label, ante, cons)
`define RSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/rsa_pkg.sv -----
// Package with constants, codes and interface types of the RSSI sweep averager.
`default_nettype none

package rsa_pkg;

  // Number of slots in one band sweep.
  localparam int unsigned SLOTS = 128;

  localparam int unsigned FreqW    = 24;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned SlotInW  = 7;
  localparam int unsigned SumW     = 16;
  localparam int unsigned CntW     = 8;
  localparam int unsigned RssiW    = 8;
  localparam int unsigned SelW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = FreqW;

  // Dividend of the averaging division: sum plus half the count.
  localparam int unsigned DivW     = SumW + 1;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  localparam logic [ByteW-1:0] RssiOffset = 8'h80;

  // Input opcodes.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Result kinds.
  localparam logic KIND_FREQ_WR = 1'b0;
  localparam logic KIND_AVERAGE = 1'b1;

  // Scan modes.
  localparam logic MODE_SWEEP = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  // Frequency register bytes.
  localparam logic [SelW-1:0] SEL_FREQ0 = 2'd0;
  localparam logic [SelW-1:0] SEL_FREQ1 = 2'd1;
  localparam logic [SelW-1:0] SEL_FREQ2 = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FREQ_START = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FREQ_STEP  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLES    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_MODE  = 2'd3;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  // Request to the shared multiply/divide unit.
  // MD_MUL: result = base + addend * operand (mod 2^24).
  // MD_DIV: result = operand / addend[7:0].
  typedef struct packed {
    logic              start;
    md_op_e            op;
    logic [FreqW-1:0]  base;
    logic [FreqW-1:0]  addend;
    logic [DivW-1:0]   operand;
  } md_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [FreqW-1:0] result;
  } md_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/rsa_muldiv.sv -----
// Iterative shift-add multiplier and restoring divider sharing one 24-bit adder.
`default_nettype none

module rsa_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsa_pkg::md_req_t req_i,
  output rsa_pkg::md_rsp_t rsp_o
);
  import rsa_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  md_op_e              op_q, op_d;
  logic [FreqW-1:0]    acc_q, acc_d;
  logic [FreqW-1:0]    aux_q, aux_d;
  logic [DivW-1:0]     opnd_q, opnd_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  logic [ByteW:0]      shifted;
  logic [FreqW-1:0]    add_a;
  logic [FreqW-1:0]    add_b;
  logic                add_cin;
  logic [FreqW:0]      add_sum;

  // Partial remainder with the next dividend bit shifted in.
  assign shifted = {acc_q[ByteW-1:0], opnd_q[DivW-1]};

  always_comb begin
    unique case (op_q)
      MD_MUL: begin
        add_a   = acc_q;
        add_b   = aux_q;
        add_cin = 1'b0;
      end
      MD_DIV: begin
        add_a   = FreqW'(shifted);
        add_b   = ~(FreqW'(aux_q[ByteW-1:0]));
        add_cin = 1'b1;
      end
      default: begin
        add_a   = acc_q;
        add_b   = aux_q;
        add_cin = 1'b0;
      end
    endcase
  end

  // In a subtraction the carry out is high when no borrow occurred.
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (FreqW + 1)'(add_cin);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    aux_d  = aux_q;
    opnd_d = opnd_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = (req_i.op == MD_DIV) ? '0 : req_i.base;
      aux_d  = req_i.addend;
      opnd_d = req_i.operand;
      cnt_d  = StepCntW'(DivSteps - 1);
    end else if (busy_q) begin
      unique case (op_q)
        MD_MUL: begin
          if (opnd_q[0]) begin
            acc_d = add_sum[FreqW-1:0];
          end
          aux_d  = aux_q << 1;
          opnd_d = opnd_q >> 1;
          if (opnd_q[DivW-1:1] == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        MD_DIV: begin
          if (add_sum[FreqW]) begin
            acc_d = add_sum[FreqW-1:0];
          end else begin
            acc_d = FreqW'(shifted);
          end
          opnd_d = {opnd_q[DivW-2:0], add_sum[FreqW]};
          cnt_d  = cnt_q - StepCntW'(1);
          if (cnt_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    aux_q  <= aux_d;
    opnd_q <= opnd_d;
    cnt_q  <= cnt_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == MD_DIV) ? FreqW'(opnd_q) : acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/rssi_sweep_averager.sv -----
// Top level of the RSSI sweep averager: config registers, sequencer and result register.
//
// Input channel (in_valid_i/in_ready_o): one transfer is a start item or an RSSI sample.
// Output channel (out_valid_o/out_ready_i): frequency byte writes and averages, zero to
// four per input item, the final one marked by last_o.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so
// while the block is idle, which the block does not enforce. The block takes one item at
// a time; in_ready_o is low from the transfer until the item's last result is loaded into
// the output register (or its handling ends with none), but a sample while no scan runs
// leaves it high. A sample that completes an average runs the 17-step restoring division
// in the shared multiply/divide unit, in sweep mode usually a multiply for the next
// frequency word, and up to four result transfers.
// A start in sweep mode runs the start-slot multiply before its byte writes.
// The output register frees the sequencer one result at a time; when the receiver stalls,
// the sequencer waits with its next result and the input stays not ready.
// Reset clears the configuration to its defaults (sample count 1), stops any scan
// and drops out_valid_o.
`default_nettype none

`include "rssi_sweep_averager_macros.svh"

module rssi_sweep_averager (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsa_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rsa_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [rsa_pkg::SlotInW-1:0]         start_slot_i,
  input  logic [rsa_pkg::FreqW-1:0]           radio_freq_i,
  input  logic signed [rsa_pkg::RssiW-1:0]    rssi_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic [rsa_pkg::SelW-1:0]            reg_select_o,
  output logic [rsa_pkg::ByteW-1:0]           reg_value_o,
  output logic [rsa_pkg::SlotInW-1:0]         slot_o,
  output logic [rsa_pkg::ByteW-1:0]           average_o,
  output logic                                sweep_done_o,
  output logic                                last_o
);
  import rsa_pkg::*;

  localparam int unsigned CmpW = SlotW + 1;
  localparam logic [CmpW-1:0] SlotsCmp     = CmpW'(SLOTS);
  localparam logic [CmpW-1:0] SlotsCmpLess = CmpW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ADV   = 3'd3;
  localparam logic [2:0] S_FREQ  = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_DUMMY = 3'd6;
  localparam logic [2:0] S_WR    = 3'd7;

  // Configuration registers.
  logic [FreqW-1:0] freq_start_q;
  logic [FreqW-1:0] freq_step_q;
  logic [CntW-1:0]  samples_q;
  logic             scan_mode_q;

  // Scan state.
  logic [2:0]       state_q, state_d;
  logic             running_q, running_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] slots_done_q, slots_done_d;
  logic [FreqW-1:0] freq_q, freq_d;
  logic [FreqW-1:0] prev_q, prev_d;
  logic [ByteW-1:0] avg_q, avg_d;
  logic [SlotW-1:0] avg_slot_q, avg_slot_d;
  logic             end_q, end_d;
  logic             dummy_q, dummy_d;
  logic             mode_q, mode_d;

  // Output register.
  logic               out_valid_q;
  logic               out_kind_q;
  logic [SelW-1:0]    out_sel_q;
  logic [ByteW-1:0]   out_val_q;
  logic [SlotInW-1:0] out_slot_q;
  logic [ByteW-1:0]   out_avg_q;
  logic               out_done_q;
  logic               out_last_q;

  logic               load;
  logic               ld_kind;
  logic [SelW-1:0]    ld_sel;
  logic [ByteW-1:0]   ld_val;
  logic [SlotInW-1:0] ld_slot;
  logic [ByteW-1:0]   ld_avg;
  logic               ld_done;
  logic               ld_last;

  logic               in_accept;
  logic               out_free;
  logic [CntW-1:0]    eff_n;
  logic [ByteW-1:0]   rssi_off;
  logic [CmpW-1:0]    slot_next;
  logic [CmpW-1:0]    slots_done_next;
  logic [FreqW-1:0]   diff;
  logic [2:0]         wr_mask;

  md_req_t md_req;
  md_rsp_t md_rsp;

  rsa_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_start_q <= '0;
      freq_step_q  <= '0;
      samples_q    <= CntW'(1);
      scan_mode_q  <= MODE_SWEEP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FREQ_START: freq_start_q <= cfg_data_i[FreqW-1:0];
        CFG_FREQ_STEP:  freq_step_q  <= cfg_data_i[FreqW-1:0];
        CFG_SAMPLES:    samples_q    <= cfg_data_i[CntW-1:0];
        CFG_SCAN_MODE:  scan_mode_q  <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign in_accept       = in_valid_i && in_ready_o;
  assign out_free        = !out_valid_q || out_ready_i;
  assign eff_n           = (samples_q == '0) ? CntW'(1) : samples_q;
  assign rssi_off        = $unsigned(rssi_i) ^ RssiOffset;
  assign slot_next       = {1'b0, slot_q} + CmpW'(1);
  assign slots_done_next = {1'b0, slots_done_q} + CmpW'(1);
  assign diff            = freq_q ^ prev_q;
  assign wr_mask         = {|diff[3*ByteW-1:2*ByteW], |diff[2*ByteW-1:ByteW], |diff[ByteW-1:0]};

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    sum_d        = sum_q;
    count_d      = count_q;
    slot_d       = slot_q;
    slots_done_d = slots_done_q;
    freq_d       = freq_q;
    prev_d       = prev_q;
    avg_d        = avg_q;
    avg_slot_d   = avg_slot_q;
    end_d        = end_q;
    dummy_d      = dummy_q;
    mode_d       = mode_q;

    md_req       = '0;
    md_req.op    = MD_MUL;

    load    = 1'b0;
    ld_kind = KIND_AVERAGE;
    ld_sel  = SEL_FREQ0;
    ld_val  = '0;
    ld_slot = '0;
    ld_avg  = '0;
    ld_done = 1'b0;
    ld_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (opcode_i == OP_START) begin
            prev_d       = radio_freq_i;
            sum_d        = '0;
            count_d      = '0;
            slots_done_d = '0;
            running_d    = 1'b1;
            if (scan_mode_q == MODE_SWEEP) begin
              slot_d         = SlotW'(start_slot_i);
              md_req.start   = 1'b1;
              md_req.op      = MD_MUL;
              md_req.base    = freq_start_q;
              md_req.addend  = freq_step_q;
              md_req.operand = DivW'(start_slot_i);
              state_d        = S_FREQ;
            end else begin
              slot_d  = '0;
              freq_d  = freq_start_q;
              state_d = S_WR;
            end
          end else if (running_q) begin
            sum_d   = sum_q + SumW'(rssi_off);
            count_d = count_q + CntW'(1);
            state_d = S_CHK;
          end
        end
      end

      S_CHK: begin
        if (count_q != '0 && count_q >= eff_n) begin
          // Rounded mean: (sum + count/2) / count.
          md_req.start   = 1'b1;
          md_req.op      = MD_DIV;
          md_req.addend  = FreqW'(count_q);
          md_req.operand = DivW'(sum_q) + DivW'(count_q >> 1);
          sum_d          = '0;
          count_d        = '0;
          state_d        = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_FREQ: begin
        if (md_rsp.done) begin
          freq_d  = md_rsp.result;
          state_d = S_WR;
        end
      end

      S_DIV: begin
        if (md_rsp.done) begin
          avg_d      = md_rsp.result[ByteW-1:0];
          avg_slot_d = slot_q;
          mode_d     = scan_mode_q;
          end_d      = 1'b0;
          dummy_d    = 1'b0;
          state_d    = S_AVG;
          if (scan_mode_q == MODE_SWEEP) begin
            if (slots_done_next >= SlotsCmp) begin
              end_d        = 1'b1;
              slots_done_d = '0;
              running_d    = 1'b0;
            end else begin
              slots_done_d = slots_done_next[SlotW-1:0];
              if (slot_next >= SlotsCmp) begin
                slot_d = '0;
                freq_d = freq_start_q;
              end else begin
                // Next frequency is the current one plus one step.
                slot_d         = slot_next[SlotW-1:0];
                md_req.start   = 1'b1;
                md_req.op      = MD_MUL;
                md_req.base    = freq_q;
                md_req.addend  = freq_step_q;
                md_req.operand = DivW'(1);
                state_d        = S_ADV;
              end
            end
          end else begin
            dummy_d = (slot_next >= SlotsCmpLess);
            slot_d  = (slot_next >= SlotsCmpLess) ? '0 : slot_next[SlotW-1:0];
          end
        end
      end

      S_ADV: begin
        if (md_rsp.done) begin
          freq_d  = md_rsp.result;
          state_d = S_AVG;
        end
      end

      S_AVG: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_AVERAGE;
          ld_slot = avg_slot_q[SlotInW-1:0];
          ld_avg  = avg_q;
          if (mode_q == MODE_SWEEP) begin
            ld_done = end_q;
            ld_last = end_q || (wr_mask == '0);
            state_d = end_q ? S_IDLE : S_WR;
          end else begin
            ld_last = !dummy_q;
            state_d = dummy_q ? S_DUMMY : S_IDLE;
          end
        end
      end

      S_DUMMY: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_AVERAGE;
          ld_slot = SlotInW'(SLOTS - 1);
          ld_done = 1'b1;
          ld_last = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_WR: begin
        // Each transfer writes the lowest byte that still differs and marks it done.
        if (wr_mask == '0) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_FREQ_WR;
          priority if (wr_mask[0]) begin
            ld_sel                  = SEL_FREQ0;
            ld_val                  = freq_q[ByteW-1:0];
            prev_d[ByteW-1:0]       = freq_q[ByteW-1:0];
            ld_last                 = (wr_mask[2:1] == '0);
          end else if (wr_mask[1]) begin
            ld_sel                  = SEL_FREQ1;
            ld_val                  = freq_q[2*ByteW-1:ByteW];
            prev_d[2*ByteW-1:ByteW] = freq_q[2*ByteW-1:ByteW];
            ld_last                 = !wr_mask[2];
          end else begin
            ld_sel                    = SEL_FREQ2;
            ld_val                    = freq_q[3*ByteW-1:2*ByteW];
            prev_d[3*ByteW-1:2*ByteW] = freq_q[3*ByteW-1:2*ByteW];
            ld_last                   = 1'b1;
          end
          if (ld_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= 1'b0;
      sum_q        <= '0;
      count_q      <= '0;
      slot_q       <= '0;
      slots_done_q <= '0;
      freq_q       <= '0;
      prev_q       <= '0;
      end_q        <= 1'b0;
      dummy_q      <= 1'b0;
      mode_q       <= MODE_SWEEP;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
      slot_q       <= slot_d;
      slots_done_q <= slots_done_d;
      freq_q       <= freq_d;
      prev_q       <= prev_d;
      end_q        <= end_d;
      dummy_q      <= dummy_d;
      mode_q       <= mode_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q      <= avg_d;
    avg_slot_q <= avg_slot_d;
    if (load) begin
      out_kind_q <= ld_kind;
      out_sel_q  <= ld_sel;
      out_val_q  <= ld_val;
      out_slot_q <= ld_slot;
      out_avg_q  <= ld_avg;
      out_done_q <= ld_done;
      out_last_q <= ld_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign reg_select_o = out_sel_q;
  assign reg_value_o  = out_val_q;
  assign slot_o       = out_slot_q;
  assign average_o    = out_avg_q;
  assign sweep_done_o = out_done_q;
  assign last_o       = out_last_q;

  // A start always leaves the idle state, so the block cannot be ready right after it.
  `RSA_ASSERT_NEXT(a_start_leaves_idle, in_valid_i && in_ready_o && opcode_i == OP_START,
                   !in_ready_o)
  // The shared unit only runs while the sequencer waits for it.
  `RSA_ASSERT(a_unit_owned, md_rsp.busy,
              state_q == S_FREQ || state_q == S_DIV || state_q == S_ADV)
  // A result that is not the last one means the sequencer still has results to give.
  `RSA_ASSERT(a_more_follows, out_valid_o && !last_o, state_q == S_WR || state_q == S_DUMMY)
  // No samples are counted while no scan runs.
  `RSA_ASSERT(a_idle_no_count, !running_q, count_q == '0)

endmodule

`default_nettype wire

// ----- tb/sweep_result_checker.sv -----
// Checker for the RSSI sweep averager: predicts each transfer's results and compares them.
module sweep_result_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsa_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rsa_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                opcode_i,
  input  logic [rsa_pkg::SlotInW-1:0]         start_slot_i,
  input  logic [rsa_pkg::FreqW-1:0]           radio_freq_i,
  input  logic [rsa_pkg::RssiW-1:0]           rssi_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                kind_i,
  input  logic [rsa_pkg::SelW-1:0]            reg_select_i,
  input  logic [rsa_pkg::ByteW-1:0]           reg_value_i,
  input  logic [rsa_pkg::SlotInW-1:0]         slot_i,
  input  logic [rsa_pkg::ByteW-1:0]           average_i,
  input  logic                                sweep_done_i,
  input  logic                                last_i,
  output int                                  errors_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [SelW-1:0]    reg_select;
    logic [ByteW-1:0]   reg_value;
    logic [SlotInW-1:0] slot;
    logic [ByteW-1:0]   average;
    logic               sweep_done;
    logic               last;
  } scan_result_t;

  scan_result_t due_results[$];
  int errors;

  // Configuration as last written.
  logic [FreqW-1:0] base_freq;
  logic [FreqW-1:0] step_freq;
  logic [ByteW-1:0] avg_len;
  logic             scan_mode;

  // Scan state.
  logic             scanning;
  logic [SumW-1:0]  rssi_sum;
  logic [CntW-1:0]  rssi_count;
  logic [SlotW-1:0] slot_idx;
  logic [SlotW-1:0] slots_seen;
  logic [FreqW-1:0] tuned_freq;
  logic [FreqW-1:0] radio_word;

  task automatic flag(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic compare_field(input string field, input logic [FreqW-1:0] got,
                               input logic [FreqW-1:0] want);
    if (got !== want) begin
      flag($sformatf("%s is %0h, expected %0h", field, got, want));
    end
  endtask

  task automatic queue_result(input logic kind, input logic [SelW-1:0] sel,
                              input logic [ByteW-1:0] value, input logic [SlotInW-1:0] slot,
                              input logic [ByteW-1:0] mean, input logic done);
    scan_result_t r;
    r = '{kind, sel, value, slot, mean, done, 1'b0};
    due_results.push_back(r);
  endtask

  // Only the frequency bytes that differ from the word in the radio get written.
  task automatic retune;
    logic [FreqW-1:0] diff;
    diff = tuned_freq ^ radio_word;
    if (diff[7:0] != 0) begin
      queue_result(KIND_FREQ_WR, SEL_FREQ0, tuned_freq[7:0], '0, '0, 1'b0);
    end
    if (diff[15:8] != 0) begin
      queue_result(KIND_FREQ_WR, SEL_FREQ1, tuned_freq[15:8], '0, '0, 1'b0);
    end
    if (diff[23:16] != 0) begin
      queue_result(KIND_FREQ_WR, SEL_FREQ2, tuned_freq[23:16], '0, '0, 1'b0);
    end
    radio_word = tuned_freq;
  endtask

  task automatic advance_scan(input logic op, input logic [SlotInW-1:0] slot_in,
                              input logic [FreqW-1:0] freq_in, input logic [RssiW-1:0] rssi_in);
    int               queued;
    logic [ByteW-1:0] n;
    logic [DivW-1:0]  dividend;
    logic [ByteW-1:0] mean;
    scan_result_t     r;
    queued = due_results.size();
    if (op == OP_START) begin
      radio_word = freq_in;
      rssi_sum = '0;
      rssi_count = '0;
      slots_seen = '0;
      scanning = 1'b1;
      if (scan_mode == MODE_SWEEP) begin
        slot_idx = {1'b0, slot_in};
        tuned_freq = base_freq + step_freq * FreqW'(slot_idx);
      end else begin
        slot_idx = '0;
        tuned_freq = base_freq;
      end
      retune();
    end else if (scanning) begin
      rssi_sum = rssi_sum + {8'd0, rssi_in ^ RssiOffset};
      rssi_count = rssi_count + 1'b1;
      n = (avg_len == 0) ? 8'd1 : avg_len;
      if (rssi_count != 0 && rssi_count >= n) begin
        dividend = {1'b0, rssi_sum} + DivW'(rssi_count >> 1);
        mean = ByteW'(dividend / DivW'(rssi_count));
        rssi_sum = '0;
        rssi_count = '0;
        if (scan_mode == MODE_SWEEP) begin
          if (32'(slots_seen) + 1 >= SLOTS) begin
            queue_result(KIND_AVERAGE, '0, '0, slot_idx[SlotInW-1:0], mean, 1'b1);
            slots_seen = '0;
            scanning = 1'b0;
          end else begin
            queue_result(KIND_AVERAGE, '0, '0, slot_idx[SlotInW-1:0], mean, 1'b0);
            slots_seen = slots_seen + 1'b1;
            if (32'(slot_idx) + 1 >= SLOTS) begin
              slot_idx = '0;
              tuned_freq = base_freq;
            end else begin
              slot_idx = slot_idx + 1'b1;
              tuned_freq = tuned_freq + step_freq;
            end
            retune();
          end
        end else begin
          queue_result(KIND_AVERAGE, '0, '0, slot_idx[SlotInW-1:0], mean, 1'b0);
          // Fixed mode pads the last slot with an empty entry and starts over.
          if (32'(slot_idx) + 1 >= SLOTS - 1) begin
            queue_result(KIND_AVERAGE, '0, '0, SlotInW'(SLOTS - 1), '0, 1'b1);
            slot_idx = '0;
          end else begin
            slot_idx = slot_idx + 1'b1;
          end
        end
      end
    end
    if (due_results.size() > queued) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  task automatic check_result;
    scan_result_t want;
    if (due_results.size() == 0) begin
      flag("result transfer with nothing expected");
    end else begin
      want = due_results.pop_front();
      compare_field("kind", kind_i, want.kind);
      compare_field("reg_select", reg_select_i, want.reg_select);
      compare_field("reg_value", reg_value_i, want.reg_value);
      compare_field("slot", slot_i, want.slot);
      compare_field("average", average_i, want.average);
      compare_field("sweep_done", sweep_done_i, want.sweep_done);
      compare_field("last", last_i, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_freq = '0;
      step_freq = '0;
      avg_len = 8'd1;
      scan_mode = MODE_SWEEP;
      scanning = 1'b0;
      rssi_sum = '0;
      rssi_count = '0;
      slot_idx = '0;
      slots_seen = '0;
      tuned_freq = '0;
      radio_word = '0;
      due_results.delete();
      errors = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREQ_START: base_freq = cfg_data_i;
          CFG_FREQ_STEP:  step_freq = cfg_data_i;
          CFG_SAMPLES:    avg_len = cfg_data_i[ByteW-1:0];
          CFG_SCAN_MODE:  scan_mode = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        advance_scan(opcode_i, start_slot_i, radio_freq_i, rssi_i);
      end
      errors_o <= errors;
      pending_o <= due_results.size();
    end
  end

endmodule

// ----- tb/rssi_sweep_averager_test.sv -----
// Testbench top for the RSSI sweep averager: clock, reset, stimulus and final verdict.
module rssi_sweep_averager_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 40;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CfgIdxW-1:0]         cfg_idx_i;
  logic [CfgDataW-1:0]        cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       opcode_i;
  logic [SlotInW-1:0]         start_slot_i;
  logic [FreqW-1:0]           radio_freq_i;
  logic signed [RssiW-1:0]    rssi_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       kind_o;
  logic [SelW-1:0]            reg_select_o;
  logic [ByteW-1:0]           reg_value_o;
  logic [SlotInW-1:0]         slot_o;
  logic [ByteW-1:0]           average_o;
  logic                       sweep_done_o;
  logic                       last_o;

  int errors;
  int pending;
  int cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  rssi_sweep_averager uut (.*);

  sweep_result_checker check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .start_slot_i (start_slot_i),
    .radio_freq_i (radio_freq_i),
    .rssi_i       (rssi_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_i       (kind_o),
    .reg_select_i (reg_select_o),
    .reg_value_i  (reg_value_o),
    .slot_i       (slot_o),
    .average_i    (average_o),
    .sweep_done_i (sweep_done_o),
    .last_i       (last_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // All four registers are rewritten on every call, one per cycle.
  task automatic load_config(input logic [FreqW-1:0] first_freq,
                             input logic [FreqW-1:0] step, input logic [ByteW-1:0] n,
                             input logic mode);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FREQ_START;
    cfg_data_i <= first_freq;
    @(posedge clk_i);
    cfg_idx_i <= CFG_FREQ_STEP;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SAMPLES;
    cfg_data_i <= CfgDataW'(n);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SCAN_MODE;
    cfg_data_i <= CfgDataW'(mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Valid is left high after the transfer so that back-to-back items need no extra edge.
  task automatic send_item(input logic op, input logic [SlotInW-1:0] slot,
                           input logic [FreqW-1:0] freq, input logic [RssiW-1:0] rssi);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    start_slot_i <= slot;
    radio_freq_i <= freq;
    rssi_i <= rssi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic scan_burst(input int count, input int start_pct);
    int i;
    for (i = 0; i < count; i++) begin
      send_item(($urandom_range(99) < start_pct) ? OP_START : OP_SAMPLE,
                SlotInW'($urandom), FreqW'($urandom), RssiW'($urandom));
    end
  endtask

  task automatic start_scan;
    send_item(OP_START, SlotInW'($urandom), FreqW'($urandom), RssiW'($urandom));
  endtask

  // Holds the sender back until every expected result has been seen, then lets the
  // block finish any work that produces no result.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OP_SAMPLE;
    start_slot_i = '0;
    radio_freq_i = '0;
    rssi_i = '0;
    send_idle_pct = 37;
    recv_idle_pct = 69;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sweep with all-ones start and step; a zero sample count acts as one.
    load_config(24'hFFFFFF, 24'hFFFFFF, 8'd0, MODE_SWEEP);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h7F);
    send_item(OP_START, 7'd127, 24'h000000, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h80);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h7F);
    send_item(OP_START, 7'd0, 24'hFFFFFF, 8'h00);
    send_item(OP_START, 7'h55, 24'h5A5A5A, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'hFF);
    send_item(OP_START, 7'h2A, 24'hA5A5A5, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h01);
    drain();

    // Fixed frequency, pairs of samples to exercise rounding.
    load_config(24'h123456, 24'h000000, 8'd2, MODE_FIXED);
    send_item(OP_START, 7'h7F, 24'h123456, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h7F);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h7F);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h80);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h81);
    send_item(OP_START, 7'd0, 24'h000000, 8'h00);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h80);
    send_item(OP_SAMPLE, 7'd0, 24'h000000, 8'h7F);
    drain();

    // One complete sweep; the final average stops the scan.
    load_config(FreqW'($urandom), FreqW'($urandom), 8'd1, MODE_SWEEP);
    start_scan();
    scan_burst(SLOTS, 0);
    drain();

    send_idle_pct = 69;
    recv_idle_pct = 37;

    // A sweep parked near the end of the band, then fixed mode while it still runs, so
    // the first average is followed by the padding entry at the last slot.
    load_config(FreqW'($urandom), FreqW'($urandom), 8'd1, MODE_SWEEP);
    send_item(OP_START, 7'd126, FreqW'($urandom), 8'h00);
    drain();
    load_config(FreqW'($urandom), FreqW'($urandom), 8'd1, MODE_FIXED);
    scan_burst(3, 0);
    drain();

    // Large sample count, then a smaller one so the pending sum is flushed at once.
    load_config(24'h000000, 24'hFFFFFF, 8'd255, MODE_FIXED);
    start_scan();
    scan_burst(6, 0);
    drain();
    load_config(24'h000000, 24'hFFFFFF, 8'd4, MODE_FIXED);
    scan_burst(1, 0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    load_config(FreqW'($urandom), FreqW'($urandom), ByteW'($urandom_range(1, 3)),
                logic'($urandom_range(1)));
    scan_burst(6, 25);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
